// File: src/triangle_span_generator_defines.svh
// Assertion macros shared by the span generator RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef TRIANGLE_SPAN_GENERATOR_DEFINES_SVH
`define TRIANGLE_SPAN_GENERATOR_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define TSG_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("span generator check failed");

// Next-cycle implication, quiet during reset
`define TSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("span generator check failed");

`endif

// File: src/tsg_pkg.sv
// Package for the triangle span generator: widths, frame size, opcodes,
// sequencer states and divider request/response types. No dependencies.
package tsg_pkg;

    localparam int COORD_W = 16;              // vertex coordinate width
    localparam int X_W     = 17;              // span x width
    localparam int NUM_W   = 34;              // signed edge numerator
    localparam int MAG_W   = NUM_W - 1;       // numerator magnitude
    localparam int DSR_W   = 16;              // edge height
    localparam int QUO_W   = 17;              // quotient bits produced
    localparam int CNT_W   = $clog2(QUO_W + 1);

    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 1024;

    localparam logic signed [X_W-1:0]     FRAME_W_X = X_W'(FRAME_WIDTH);
    localparam logic signed [COORD_W-1:0] FRAME_H_Y = COORD_W'(FRAME_HEIGHT);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } tsg_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_SUM,
        ST_DIV_START,
        ST_DIV,
        ST_STORE,
        ST_EMIT
    } tsg_state_t;

    typedef struct packed
    {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed
    {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: src/tsg_in_if.sv
// Command channel: valid/ready handshake with a load or step transaction.
// Depends on nothing.
interface tsg_in_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] cx;
    logic signed [15:0] cy;

    modport source (output valid, opcode, ax, ay, bx, by, cx, cy, input ready);
    modport sink   (input valid, opcode, ax, ay, bx, by, cx, cy, output ready);
endinterface

// File: src/tsg_out_if.sv
// Span channel: valid/ready handshake carrying one span result per transaction.
// Depends on nothing.
interface tsg_out_if;
    logic               valid;
    logic               ready;
    logic               span_valid;
    logic signed [15:0] span_y;
    logic signed [16:0] x_long;
    logic signed [16:0] x_short;
    logic               end_in_frame;
    logic               last_span;

    modport source (output valid, span_valid, span_y, x_long, x_short, end_in_frame,
                    last_span, input ready);
    modport sink   (input valid, span_valid, span_y, x_long, x_short, end_in_frame,
                    last_span, output ready);
endinterface

// File: src/tsg_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle, QUO_W bits total.
// Depends on tsg_pkg and the assertion macros header.
`include "triangle_span_generator_defines.svh"

module tsg_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  tsg_pkg::div_req_t req,
    output tsg_pkg::div_rsp_t rsp
);
    import tsg_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] dvd_reg, dvd_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;
    logic [DSR_W:0]   rem_sh;
    logic [DSR_W:0]   rem_diff;
    logic             fits;

    // One trial subtraction; dividend bits shift out, quotient bits shift in
    assign rem_sh   = {rem_reg, dvd_reg[QUO_W-1]};
    assign rem_diff = rem_sh - {1'b0, dsr_reg};
    assign fits     = (rem_sh >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            // high part of the dividend is already below the divisor
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = req.dividend[MAG_W-1 -: DSR_W];
            dvd_next  = req.dividend[QUO_W-1:0];
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
            dvd_next = {dvd_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

    `TSG_ASSERT_IMPLIES(a_no_restart, req.start, !busy_reg)
    `TSG_ASSERT_NEXT(a_start_loads, req.start, busy_reg && cnt_reg == CNT_W'(QUO_W))
    `TSG_ASSERT_IMPLIES(a_rem_below_divisor, busy_reg, rem_reg < dsr_reg)

endmodule

// File: src/triangle_span_generator.sv
// Load: accepted in IDLE; the result is registered in EMIT once the output register is free.
// Step with a span pending: the long edge and then the short edge are evaluated, each through the
// multiply (MUL_A, MUL_B), add (SUM), sign capture and divider start (DIV_START), serial divide
// (DIV) and store (STORE) states on one multiplier; the result is then registered in EMIT.
// Step with nothing pending: goes straight to EMIT. One command in flight at a time.
// Reset (asynchronous, active low) clears vertices, scan state and the output valid flag.
`include "triangle_span_generator_defines.svh"

module triangle_span_generator
(
    input  logic clk,
    input  logic rst_n,
    tsg_in_if.sink    cmd,
    tsg_out_if.source span
);
    import tsg_pkg::*;

    tsg_state_t state_reg, state_next;

    // triangle and scan state
    logic signed [COORD_W-1:0] vx_reg[3];
    logic signed [COORD_W-1:0] vy_reg[3];
    logic signed [COORD_W-1:0] scan_y_reg;
    logic                      seg_reg;
    logic                      pend_reg;

    // per-item working registers
    logic                      item_span_reg;
    logic                      edge_reg;
    logic signed [NUM_W-1:0]   acc_reg;
    logic signed [NUM_W-1:0]   prod_reg;
    logic signed [NUM_W-1:0]   num_reg;
    logic                      sign_reg;
    logic signed [X_W-1:0]     xl_reg;
    logic signed [X_W-1:0]     xs_reg;

    // output register
    logic                      out_valid_reg;
    logic                      o_span_valid_reg;
    logic signed [COORD_W-1:0] o_span_y_reg;
    logic signed [X_W-1:0]     o_x_long_reg;
    logic signed [X_W-1:0]     o_x_short_reg;
    logic                      o_in_frame_reg;
    logic                      o_last_reg;

    logic      accept;
    logic      out_free;
    logic      out_load;
    logic      mul_sel_h;
    logic      div_start;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    // sorted load vertices
    logic signed [COORD_W-1:0] sx[3];
    logic signed [COORD_W-1:0] sy[3];

    // edge operands
    logic signed [COORD_W-1:0] ex_a, ey_a, ex_b, ey_b;
    logic signed [COORD_W:0]   h_full, t_full, dx;
    logic        [DSR_W-1:0]   h;
    logic        [DSR_W-1:0]   t;
    logic signed [X_W-1:0]     mul_a, mul_b;
    logic signed [NUM_W-1:0]   product;
    logic signed [NUM_W-1:0]   num_neg;
    logic signed [X_W-1:0]     quo_signed;

    // scan advance after a span
    logic signed [COORD_W:0]   y_after;
    logic                      seg_after;
    logic                      pend_after;
    logic                      in_frame;

    assign out_free = !out_valid_reg || span.ready;
    assign accept   = cmd.valid && cmd.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_STEP && pend_reg)
                        state_next = ST_MUL_A;
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_MUL_A:     state_next = ST_MUL_B;
            ST_MUL_B:     state_next = ST_SUM;
            ST_SUM:       state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                    state_next = ST_STORE;
            end
            ST_STORE:     state_next = edge_reg ? ST_EMIT : ST_MUL_A;
            ST_EMIT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        mul_sel_h = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:      cmd.ready = 1'b1;
            ST_MUL_A:     mul_sel_h = 1'b1;
            ST_DIV_START: div_start = 1'b1;
            ST_EMIT:      out_load  = out_free;
            ST_MUL_B, ST_SUM, ST_DIV, ST_STORE: ;
            default:      ;
        endcase
    end

    // stable three-element bubble sort by y
    always_comb
    begin
        logic signed [COORD_W-1:0] tx, ty;
        tx = '0;
        ty = '0;
        sx[0] = cmd.ax; sy[0] = cmd.ay;
        sx[1] = cmd.bx; sy[1] = cmd.by;
        sx[2] = cmd.cx; sy[2] = cmd.cy;
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2])
        begin
            tx = sx[1]; ty = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1])
        begin
            tx = sx[0]; ty = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tx; sy[1] = ty;
        end
    end

    // edge select: long edge v0->v2, short edge v0->v1 or v1->v2
    always_comb
    begin
        if (!edge_reg)
        begin
            ex_a = vx_reg[0]; ey_a = vy_reg[0];
            ex_b = vx_reg[2]; ey_b = vy_reg[2];
        end
        else if (!seg_reg)
        begin
            ex_a = vx_reg[0]; ey_a = vy_reg[0];
            ex_b = vx_reg[1]; ey_b = vy_reg[1];
        end
        else
        begin
            ex_a = vx_reg[1]; ey_a = vy_reg[1];
            ex_b = vx_reg[2]; ey_b = vy_reg[2];
        end
    end

    assign h_full = (COORD_W+1)'(ey_b) - (COORD_W+1)'(ey_a);
    assign t_full = (COORD_W+1)'(scan_y_reg) - (COORD_W+1)'(ey_a);
    assign dx     = (COORD_W+1)'(ex_b) - (COORD_W+1)'(ex_a);
    assign h      = h_full[DSR_W-1:0];
    assign t      = t_full[DSR_W-1:0];

    // shared multiplier: xa*h, then dx*t
    assign mul_a   = mul_sel_h ? X_W'(ex_a) : dx;
    assign mul_b   = mul_sel_h ? $signed({1'b0, h}) : $signed({1'b0, t});
    assign product = mul_a * mul_b;

    assign num_neg    = -num_reg;
    assign quo_signed = sign_reg ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);

    assign div_req.start    = div_start;
    assign div_req.dividend = num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
    assign div_req.divisor  = h;

    tsg_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // move the scan to the next segment or end it
    always_comb
    begin
        y_after    = (COORD_W+1)'(scan_y_reg) + (COORD_W+1)'(1);
        seg_after  = seg_reg;
        pend_after = 1'b1;
        if (!seg_reg && y_after >= (COORD_W+1)'(vy_reg[1]))
        begin
            if (vy_reg[1] == vy_reg[2])
                pend_after = 1'b0;
            else
                seg_after = 1'b1;
        end
        if (seg_after && y_after >= (COORD_W+1)'(vy_reg[2]))
            pend_after = 1'b0;
    end

    assign in_frame = (xs_reg >= 0) && (xs_reg < FRAME_W_X)
                   && (scan_y_reg >= 0) && (scan_y_reg < FRAME_H_Y);

    // control and triangle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                vx_reg[i] <= '0;
                vy_reg[i] <= '0;
            end
            scan_y_reg    <= '0;
            seg_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            item_span_reg <= 1'b0;
            edge_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                edge_reg      <= 1'b0;
                item_span_reg <= (cmd.opcode == OP_STEP) && pend_reg;
                if (cmd.opcode == OP_LOAD)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vx_reg[i] <= sx[i];
                        vy_reg[i] <= sy[i];
                    end
                    scan_y_reg <= sy[0];
                    seg_reg    <= (sy[0] == sy[1]);
                    pend_reg   <= (sy[0] != sy[2]);
                end
            end
            if (state_reg == ST_STORE)
                edge_reg <= !edge_reg;
            if (out_load && item_span_reg)
            begin
                scan_y_reg <= y_after[COORD_W-1:0];
                seg_reg    <= seg_after;
                pend_reg   <= pend_after;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (span.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic and output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL_A)
            acc_reg <= product;
        if (state_reg == ST_MUL_B)
            prod_reg <= product;
        if (state_reg == ST_SUM)
            num_reg <= acc_reg + prod_reg;
        if (state_reg == ST_DIV_START)
            sign_reg <= num_reg[NUM_W-1];
        if (state_reg == ST_STORE)
        begin
            if (!edge_reg)
                xl_reg <= quo_signed;
            else
                xs_reg <= quo_signed;
        end
        if (out_load)
        begin
            o_span_valid_reg <= item_span_reg;
            o_span_y_reg     <= item_span_reg ? scan_y_reg : '0;
            o_x_long_reg     <= item_span_reg ? xl_reg : '0;
            o_x_short_reg    <= item_span_reg ? xs_reg : '0;
            o_in_frame_reg   <= item_span_reg && in_frame;
            o_last_reg       <= item_span_reg && !pend_after;
        end
    end

    assign span.valid        = out_valid_reg;
    assign span.span_valid   = o_span_valid_reg;
    assign span.span_y       = o_span_y_reg;
    assign span.x_long       = o_x_long_reg;
    assign span.x_short      = o_x_short_reg;
    assign span.end_in_frame = o_in_frame_reg;
    assign span.last_span    = o_last_reg;

    `TSG_ASSERT_IMPLIES(a_empty_result_zero, span.valid && !span.span_valid,
        span.span_y == '0 && span.x_long == '0 && span.x_short == '0
        && !span.end_in_frame && !span.last_span)
    `TSG_ASSERT_IMPLIES(a_vertices_sorted, pend_reg,
        vy_reg[0] <= vy_reg[1] && vy_reg[1] <= vy_reg[2])
    `TSG_ASSERT_IMPLIES(a_scan_in_range, pend_reg,
        scan_y_reg >= vy_reg[0] && scan_y_reg < vy_reg[2])
    `TSG_ASSERT_IMPLIES(a_div_done_in_wait, div_rsp.done, state_reg == ST_DIV)

endmodule
